FILE: hw/rtl/aet_pkg.sv
// Package for the attention entropy telemetry block: sizes, codes and limits.
// Used by every module of the block but aet_ram; depends on nothing.
`timescale 1ns / 1ps
package aet_pkg;
  localparam int MAX_LAYERS = 32;
  localparam int MAX_HEADS  = 32;
  localparam int MAX_SEQ    = 4096;
  localparam int LAYER_W    = 5;
  localparam int HEAD_W     = 5;
  localparam int STORE_AW   = LAYER_W + HEAD_W;
  localparam int STORE_DEPTH = MAX_LAYERS * MAX_HEADS;
  localparam int ENT_W      = 24;
  localparam int ACC_W      = 28;
  localparam int CNT_W      = 13;
  localparam int POS_W      = 12;
  localparam int WEIGHT_W   = 17;
  localparam int SUM_W      = 29;
  localparam int PEAK_W     = WEIGHT_W + POS_W;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [ACC_W-1:0]    ACC_MAX = 28'hFFFFFFF;
  localparam logic [ENT_W-1:0]    ENT_MAX = 24'hFFFFFF;
  localparam logic [CNT_W-1:0]    SEQ_LIMIT = 13'd4096;
  localparam logic [5:0]          LAYER_LIMIT = 6'd32;
  localparam logic [5:0]          HEAD_LIMIT  = 6'd32;

  localparam logic [1:0] KIND_HEAD   = 2'd0;
  localparam logic [1:0] KIND_LAYER  = 2'd1;
  localparam logic [1:0] KIND_GLOBAL = 2'd2;

  localparam logic [1:0] REG_LAYERS    = 2'd0;
  localparam logic [1:0] REG_HEADS     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic ACT_WEIGHT   = 1'b0;
  localparam logic ACT_FINALIZE = 1'b1;
endpackage

FILE: hw/rtl/aet_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module aet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/aet_div.sv
// Restoring divider, one quotient bit per cycle, for the layer and global means.
// Depends on aet_pkg for the dividend width.
`timescale 1ns / 1ps
module aet_div
  import aet_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [5:0]       divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);
  logic             busy;
  logic [4:0]       steps;
  logic [SUM_W-1:0] dvd;
  logic [5:0]       dvs;
  logic [6:0]       rem;
  logic [6:0]       rem_shift;
  logic             fits;

  assign rem_shift = {rem[5:0], dvd[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 5'(SUM_W - 1);
        dvd   <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem      <= fits ? rem_shift - {1'b0, dvs} : rem_shift;
        dvd      <= {dvd[SUM_W-2:0], 1'b0};
        quotient <= {quotient[SUM_W-2:0], fits};
        if (steps == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          steps <= steps - 5'd1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/attention_entropy_telemetry.sv
// Top level of the attention entropy telemetry block.
// Depends on aet_pkg, aet_ram (head store and layer peak store) and aet_div.
`timescale 1ns / 1ps
// After reset the block sweeps the head entropy store and the layer peak store to
// zero, and accepts no item in that time; configuration writes are taken at any
// time. Items are handled one at a time. A weight whose probability lies strictly
// between zero and one is accepted, has its tags checked and its leading one
// found, then goes through sixteen square-and-compare steps on a 16 by 16
// multiplier for the fractional log2; then the term is formed and the state updated.
// A weight of zero or one goes from the tag check straight to the update, and an
// item whose layer or head is beyond the counts in use gives nothing.
// A finalize transaction walks the head store entry by entry, reading and then
// adding each one, and divides each layer sum with a serial divider; it also
// waits while the result side stalls.
// Results leave through an output register, so the next item is accepted
// while a head result still waits to be taken.
module attention_entropy_telemetry
  import aet_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [ENT_W-1:0]    cfg_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                action,
  input  logic [7:0]          layer_sel,
  input  logic [7:0]          head_sel,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic                last_element,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [1:0]          kind,
  output logic [LAYER_W-1:0]  layer_out,
  output logic [HEAD_W-1:0]   head_out,
  output logic [ENT_W-1:0]    entropy,
  output logic [WEIGHT_W-1:0] peak_weight,
  output logic [POS_W-1:0]    peak_position,
  output logic                focused,
  output logic                last_result
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_LEAD  = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FACC  = 4'd8;
  localparam logic [3:0] S_FDIV  = 4'd9;
  localparam logic [3:0] S_FEMIT = 4'd10;
  localparam logic [3:0] S_GDIV  = 4'd11;
  localparam logic [3:0] S_GEMIT = 4'd12;

  logic [3:0] state;

  // Configuration registers, kept as written; the effective counts are
  // clamped to the range that the stores hold.
  logic [5:0]       layers_in_use;
  logic [5:0]       heads_in_use;
  logic [ENT_W-1:0] focus_threshold;
  logic [5:0]       nl;
  logic [5:0]       nh;

  assign cfg_ready = 1'b1;
  assign nl = (layers_in_use == 6'd0) ? 6'd1 :
              (layers_in_use > LAYER_LIMIT) ? LAYER_LIMIT : layers_in_use;
  assign nh = (heads_in_use == 6'd0) ? 6'd1 :
              (heads_in_use > HEAD_LIMIT) ? HEAD_LIMIT : heads_in_use;

  // Latched item.
  logic [7:0]          lay;
  logic [7:0]          hd;
  logic [WEIGHT_W-1:0] w;
  logic                last;

  // Running vector state.
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] count;

  // Log2 datapath.
  logic [3:0]  lead;
  logic [3:0]  lead_pos;
  logic [15:0] x;
  logic [15:0] frac;
  logic [3:0]  step;
  logic [31:0] x_sq;
  logic [16:0] x_t;
  logic [20:0] negl;
  logic [36:0] prod;
  logic [20:0] term;

  // Finalize walk.
  logic [LAYER_W-1:0] fl;
  logic [HEAD_W-1:0]  fh;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]   total;
  logic [ENT_W-1:0]   mean;

  // Clearing sweep.
  logic [STORE_AW-1:0] clr;

  // Memories.
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [ENT_W-1:0]    store_wdata;
  logic [STORE_AW-1:0] store_raddr;
  logic [ENT_W-1:0]    store_rdata;
  logic                peak_we;
  logic [LAYER_W-1:0]  peak_waddr;
  logic [PEAK_W-1:0]   peak_wdata;
  logic [LAYER_W-1:0]  peak_raddr;
  logic [PEAK_W-1:0]   peak_rdata;

  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [5:0]          div_divisor;
  logic                div_done;
  logic [SUM_W-1:0]    div_quotient;

  // Update step signals.
  logic                emit_ok;
  logic                emit_now;
  logic                in_range;
  logic                trivial_w;
  logic [ACC_W:0]      acc_sum;
  logic [ACC_W-1:0]    acc_new;
  logic [CNT_W-1:0]    count_new;
  logic [POS_W-1:0]    pos;
  logic                new_peak;
  logic [WEIGHT_W-1:0] pw_new;
  logic [POS_W-1:0]    pp_new;
  logic [ENT_W-1:0]    close_ent;
  logic                upd_go;
  logic                fin_state;

  assign item_ready = (state == S_IDLE);
  assign emit_ok    = !result_valid || result_ready;
  assign in_range   = ({1'b0, lay[4:0]} < nl) && (lay[7:5] == 3'd0) &&
                      ({1'b0, hd[4:0]} < nh) && (hd[7:5] == 3'd0);
  assign trivial_w  = (w == '0) || w[16];

  always_comb begin
    lead_pos = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (w[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  assign x_sq = x * x;
  assign x_t  = x_sq[31:15];
  assign negl = 21'd1048576 - {1'b0, lead, frac};
  assign prod = w[15:0] * negl;

  assign acc_sum   = {1'b0, acc} + {8'd0, term};
  assign acc_new   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign pos       = count[CNT_W-1] ? POS_W'(MAX_SEQ - 1) : count[POS_W-1:0];
  assign count_new = (count < SEQ_LIMIT) ? count + 13'd1 : count;
  assign new_peak  = w > peak_rdata[PEAK_W-1:POS_W];
  assign pw_new    = new_peak ? w : peak_rdata[PEAK_W-1:POS_W];
  assign pp_new    = new_peak ? pos : peak_rdata[POS_W-1:0];
  assign close_ent = (count_new > 13'd1) ?
                     ((acc_new > {4'd0, ENT_MAX}) ? ENT_MAX : acc_new[ENT_W-1:0]) : '0;
  assign upd_go    = (state == S_UPD) && (!last || emit_ok);

  // A result is loaded into the output register on a closing update or a summary step.
  assign emit_now  = (upd_go && last) ||
                     (((state == S_FEMIT) || (state == S_GEMIT)) && emit_ok);

  assign fin_state = (state == S_FRD) || (state == S_FACC) || (state == S_FDIV) ||
                     (state == S_FEMIT);
  assign sum_next  = sum + {5'd0, store_rdata};
  assign mean      = div_quotient[ENT_W-1:0];

  // Memory ports: the clearing sweep owns the write ports until it ends.
  always_comb begin
    store_we    = 1'b0;
    store_waddr = {lay[LAYER_W-1:0], hd[HEAD_W-1:0]};
    store_wdata = close_ent;
    peak_we     = 1'b0;
    peak_waddr  = lay[LAYER_W-1:0];
    peak_wdata  = {pw_new, pp_new};
    if (state == S_CLEAR) begin
      store_we    = 1'b1;
      store_waddr = clr;
      store_wdata = '0;
      peak_we     = (clr[STORE_AW-1:LAYER_W] == '0);
      peak_waddr  = clr[LAYER_W-1:0];
      peak_wdata  = '0;
    end else if (upd_go) begin
      store_we = last;
      peak_we  = new_peak;
    end
  end

  assign store_raddr = {fl, fh};
  assign peak_raddr  = fin_state ? fl : lay[LAYER_W-1:0];

  aet_ram #(.WIDTH(ENT_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_waddr),
    .wr_data (store_wdata),
    .rd_addr (store_raddr),
    .rd_data (store_rdata)
  );

  aet_ram #(.WIDTH(PEAK_W), .DEPTH(MAX_LAYERS)) u_peak (
    .clk     (clk),
    .wr_en   (peak_we),
    .wr_addr (peak_waddr),
    .wr_data (peak_wdata),
    .rd_addr (peak_raddr),
    .rd_data (peak_rdata)
  );

  aet_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_next;
    div_divisor  = nh;
    if ((state == S_FACC) && ({1'b0, fh} == nh - 6'd1)) begin
      div_start = 1'b1;
    end else if ((state == S_FEMIT) && emit_ok && ({1'b0, fl} == nl - 6'd1)) begin
      div_start    = 1'b1;
      div_dividend = total + {5'd0, mean};
      div_divisor  = nl;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      layers_in_use   <= LAYER_LIMIT;
      heads_in_use    <= HEAD_LIMIT;
      focus_threshold <= 24'd163840;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LAYERS:    layers_in_use   <= cfg_data[5:0];
        REG_HEADS:     heads_in_use    <= cfg_data[5:0];
        REG_THRESHOLD: focus_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      acc          <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_now || (result_valid && !result_ready);
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            lay  <= layer_sel;
            hd   <= head_sel;
            w    <= (weight > ONE_Q16) ? ONE_Q16 : weight;
            last <= last_element;
            fl   <= '0;
            fh   <= '0;
            sum  <= '0;
            total <= '0;
            state <= (action == ACT_FINALIZE) ? S_FRD : S_PREP;
          end
        end
        S_PREP: begin
          if (!in_range) begin
            state <= S_IDLE;
          end else if (trivial_w) begin
            term  <= '0;
            state <= S_UPD;
          end else begin
            state <= S_LEAD;
          end
        end
        S_LEAD: begin
          lead  <= lead_pos;
          x     <= w[15:0] << (4'd15 - lead_pos);
          frac  <= '0;
          step  <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          frac <= {frac[14:0], x_t[16]};
          x    <= x_t[16] ? x_t[16:1] : x_t[15:0];
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          term  <= prod[36:16];
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            if (last) begin
              acc           <= '0;
              count         <= '0;
              kind          <= KIND_HEAD;
              layer_out     <= lay[LAYER_W-1:0];
              head_out      <= hd[HEAD_W-1:0];
              entropy       <= close_ent;
              peak_weight   <= pw_new;
              peak_position <= pp_new;
              focused       <= 1'b0;
              last_result   <= 1'b0;
            end else begin
              acc   <= acc_new;
              count <= count_new;
            end
            state <= S_IDLE;
          end
        end
        S_FRD: begin
          state <= S_FACC;
        end
        S_FACC: begin
          sum <= sum_next;
          if ({1'b0, fh} == nh - 6'd1) begin
            state <= S_FDIV;
          end else begin
            fh    <= fh + 1'b1;
            state <= S_FRD;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            state <= S_FEMIT;
          end
        end
        S_FEMIT: begin
          if (emit_ok) begin
            kind          <= KIND_LAYER;
            layer_out     <= fl;
            head_out      <= '0;
            entropy       <= mean;
            peak_weight   <= peak_rdata[PEAK_W-1:POS_W];
            peak_position <= peak_rdata[POS_W-1:0];
            focused       <= 1'b0;
            last_result   <= 1'b0;
            total         <= total + {5'd0, mean};
            if ({1'b0, fl} == nl - 6'd1) begin
              state <= S_GDIV;
            end else begin
              fl    <= fl + 1'b1;
              fh    <= '0;
              sum   <= '0;
              state <= S_FRD;
            end
          end
        end
        S_GDIV: begin
          if (div_done) begin
            state <= S_GEMIT;
          end
        end
        S_GEMIT: begin
          if (emit_ok) begin
            kind          <= KIND_GLOBAL;
            layer_out     <= '0;
            head_out      <= '0;
            entropy       <= mean;
            peak_weight   <= '0;
            peak_position <= '0;
            focused       <= mean < focus_threshold;
            last_result   <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/aet_checker.sv
// Port-level checker for the attention entropy telemetry block, and its bind.
// Depends on aet_pkg for the field widths, the result kind codes and ONE_Q16.
`timescale 1ns / 1ps
module aet_checker
  import aet_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [1:0]          kind,
  input logic [LAYER_W-1:0]  layer_out,
  input logic [HEAD_W-1:0]   head_out,
  input logic [ENT_W-1:0]    entropy,
  input logic [WEIGHT_W-1:0] peak_weight,
  input logic [POS_W-1:0]    peak_position,
  input logic                focused,
  input logic                last_result
);
  // A stalled result stays valid and keeps its entropy and kind.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(entropy) && $stable(kind))
    else $error("result changed while stalled");

  // Only the global summary closes a run or carries the focus flag.
  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_GLOBAL |-> !last_result && !focused)
    else $error("last or focus flag on a non-global result");

  // The global summary carries no layer, head or peak.
  a_global: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_GLOBAL |->
      last_result && layer_out == '0 && head_out == '0 &&
      peak_weight == '0 && peak_position == '0)
    else $error("global summary carries stray fields");

  // Peaks are probabilities and never exceed one; layer results have no head.
  a_peak: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> peak_weight <= ONE_Q16 &&
      (kind != KIND_LAYER || head_out == '0))
    else $error("peak above one or head on a layer result");
endmodule

bind attention_entropy_telemetry aet_checker u_aet_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .kind          (kind),
  .layer_out     (layer_out),
  .head_out      (head_out),
  .entropy       (entropy),
  .peak_weight   (peak_weight),
  .peak_position (peak_position),
  .focused       (focused),
  .last_result   (last_result)
);

FILE: test/tb_attention_entropy_telemetry.sv
// Self-checking testbench for attention_entropy_telemetry: entropy, peak and summary results
// are predicted transaction by transaction and compared field by field.
// Depends on aet_pkg and the attention_entropy_telemetry RTL.
`timescale 1ns / 1ps
module tb_attention_entropy_telemetry;
  import aet_pkg::*;

  // One result as the block should present it.
  typedef struct {
    logic [1:0]          kind;
    logic [LAYER_W-1:0]  layer;
    logic [HEAD_W-1:0]   head;
    logic [ENT_W-1:0]    ent;
    logic [WEIGHT_W-1:0] pk_w;
    logic [POS_W-1:0]    pk_p;
    logic                foc;
    logic                fin;
  } telemetry_t;

  // The tracker keeps its own copy of the block's state and configuration, works out the
  // results that each accepted transaction must give, and checks results in order.
  class entropy_tracker;
    logic [5:0]          layers_reg = 6'd32;
    logic [5:0]          heads_reg = 6'd32;
    logic [ENT_W-1:0]    thresh_reg = 24'd163840;
    logic [ENT_W-1:0]    head_ent[STORE_DEPTH];
    logic [WEIGHT_W-1:0] peak_w[MAX_LAYERS];
    logic [POS_W-1:0]    peak_p[MAX_LAYERS];
    logic [ACC_W-1:0]    acc;
    logic [CNT_W-1:0]    n_elem;
    telemetry_t          pending[$];
    int                  errors;

    function new();
      foreach (head_ent[i]) head_ent[i] = '0;
      foreach (peak_w[i]) begin
        peak_w[i] = '0;
        peak_p[i] = '0;
      end
      acc = '0;
      n_elem = '0;
      errors = 0;
    endfunction

    function int unsigned active_layers();
      if (layers_reg == 0) return 1;
      return (layers_reg > MAX_LAYERS) ? MAX_LAYERS : layers_reg;
    endfunction

    function int unsigned head_count();
      if (heads_reg == 0) return 1;
      return (heads_reg > MAX_HEADS) ? MAX_HEADS : heads_reg;
    endfunction

    // -p*log2(p) in Q.16: leading one, then sixteen square-and-compare steps, truncated.
    function longint unsigned info_term(longint unsigned p);
      longint unsigned ex;
      longint unsigned x;
      longint unsigned frac;
      longint unsigned neg_log;
      ex = 15;
      frac = 0;
      while (ex > 0 && ((p >> ex) & 1) == 0) ex--;
      x = p << (15 - ex);
      for (int i = 0; i < 16; i++) begin
        x = (x * x) >> 15;
        frac = frac << 1;
        if (x >= 65536) begin
          frac = frac | 1;
          x = x >> 1;
        end
      end
      neg_log = (64'd16 << 16) - ((ex << 16) + frac);
      return (p * neg_log) >> 16;
    endfunction

    function void set_reg(logic [1:0] idx, logic [ENT_W-1:0] val);
      if (idx == REG_LAYERS) layers_reg = val[5:0];
      else if (idx == REG_HEADS) heads_reg = val[5:0];
      else if (idx == REG_THRESHOLD) thresh_reg = val;
    endfunction

    function void note_item(logic act, logic [7:0] lay, logic [7:0] hd,
                            logic [WEIGHT_W-1:0] w_in, logic lst);
      int unsigned nl;
      int unsigned nh;
      int unsigned total;
      int unsigned sum;
      longint unsigned s;
      logic [WEIGHT_W-1:0] w;
      logic [POS_W-1:0] pos;
      logic [ENT_W-1:0] ent;
      logic [ENT_W-1:0] g;
      telemetry_t r;
      nl = active_layers();
      nh = head_count();
      if (act == ACT_FINALIZE) begin
        total = 0;
        for (int l = 0; l < nl; l++) begin
          sum = 0;
          for (int h = 0; h < nh; h++) sum += head_ent[l * MAX_HEADS + h];
          r = '{KIND_LAYER, LAYER_W'(l), '0, ENT_W'(sum / nh), peak_w[l], peak_p[l],
                1'b0, 1'b0};
          total += sum / nh;
          pending.push_back(r);
        end
        g = ENT_W'(total / nl);
        r = '{KIND_GLOBAL, '0, '0, g, '0, '0, g < thresh_reg, 1'b1};
        pending.push_back(r);
        return;
      end
      if (lay >= nl || hd >= nh) return;
      w = (w_in > ONE_Q16) ? ONE_Q16 : w_in;
      pos = (n_elem < SEQ_LIMIT) ? n_elem[POS_W-1:0] : POS_W'(MAX_SEQ - 1);
      if (w != 0 && w < ONE_Q16) begin
        s = acc + info_term(w);
        acc = (s > ACC_MAX) ? ACC_MAX : s[ACC_W-1:0];
      end
      if (w > peak_w[lay]) begin
        peak_w[lay] = w;
        peak_p[lay] = pos;
      end
      if (n_elem < SEQ_LIMIT) n_elem++;
      if (lst) begin
        ent = '0;
        if (n_elem > 1) ent = (acc > ENT_MAX) ? ENT_MAX : acc[ENT_W-1:0];
        head_ent[lay * MAX_HEADS + hd] = ent;
        acc = '0;
        n_elem = '0;
        r = '{KIND_HEAD, lay[4:0], hd[4:0], ent, peak_w[lay], peak_p[lay], 1'b0, 1'b0};
        pending.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(telemetry_t got);
      telemetry_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d layer %0d head %0d",
                         got.kind, got.layer, got.head));
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("kind %0d, want %0d", got.kind, exp.kind));
      if (got.layer !== exp.layer)
        report($sformatf("layer_out %0d, want %0d", got.layer, exp.layer));
      if (got.head !== exp.head)
        report($sformatf("head_out %0d, want %0d", got.head, exp.head));
      if (got.ent !== exp.ent)
        report($sformatf("entropy %0d, want %0d", got.ent, exp.ent));
      if (got.pk_w !== exp.pk_w)
        report($sformatf("peak_weight %0d, want %0d", got.pk_w, exp.pk_w));
      if (got.pk_p !== exp.pk_p)
        report($sformatf("peak_position %0d, want %0d", got.pk_p, exp.pk_p));
      if (got.foc !== exp.foc)
        report($sformatf("focused %0d, want %0d", got.foc, exp.foc));
      if (got.fin !== exp.fin)
        report($sformatf("last_result %0d, want %0d", got.fin, exp.fin));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [ENT_W-1:0]    cfg_data = '0;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic                action = 1'b0;
  logic [7:0]          layer_sel = '0;
  logic [7:0]          head_sel = '0;
  logic [WEIGHT_W-1:0] weight = '0;
  logic                last_element = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [1:0]          kind;
  logic [LAYER_W-1:0]  layer_out;
  logic [HEAD_W-1:0]   head_out;
  logic [ENT_W-1:0]    entropy;
  logic [WEIGHT_W-1:0] peak_weight;
  logic [POS_W-1:0]    peak_position;
  logic                focused;
  logic                last_result;

  // When quiet is set neither side idles; hold_req asks the result side for a long stall.
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  entropy_tracker tracker = new();

  attention_entropy_telemetry dut (.*);

  always #5 clk = ~clk;

  // Results are sampled in the active region just after the edge, so the handshake seen here
  // is the one that the block saw at that edge.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      tracker.check_result('{kind, layer_out, head_out, entropy, peak_weight,
                             peak_position, focused, last_result});
  end

  // Result side: random stalls in bursts, one long hold-off on request, none when quiet.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        result_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Writes all three registers back to back, then drops the write valid.
  task set_config(logic [ENT_W-1:0] lay_val, logic [ENT_W-1:0] head_val,
                  logic [ENT_W-1:0] thr_val);
    logic [1:0]       idx[3];
    logic [ENT_W-1:0] val[3];
    idx = '{REG_LAYERS, REG_HEADS, REG_THRESHOLD};
    val = '{lay_val, head_val, thr_val};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers one transaction, with a random gap in front unless quiet, and returns at the edge
  // where it is accepted; valid is left high so that the next transaction can follow at once.
  task send_item(logic act, logic [7:0] lay, logic [7:0] hd, logic [WEIGHT_W-1:0] w,
                 logic lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    layer_sel <= lay;
    head_sel <= hd;
    weight <= w;
    last_element <= lst;
    do @(posedge clk); while (!item_ready);
    tracker.note_item(act, lay, hd, w, lst);
  endtask

  // Weights are skewed towards the edges: zero, exactly one, above one (clamped), and the rest.
  function logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_Q16;
      2: return WEIGHT_W'($urandom_range(65537, 131071));
      default: return WEIGHT_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // Mostly well-formed vectors for a tracked (layer, head); the rest is out-of-range noise,
  // vectors left open so that the next one is summed into them, and the odd finalize.
  task random_traffic(int n_items);
    int unsigned nl;
    int unsigned nh;
    int sent;
    int len;
    logic [7:0] lay;
    logic [7:0] hd;
    sent = 0;
    while (sent < n_items) begin
      nl = tracker.active_layers();
      nh = tracker.head_count();
      case ($urandom_range(0, 9))
        8: begin
          if ($urandom_range(0, 1) == 0) send_item(ACT_WEIGHT, 8'($urandom_range(nl, 255)),
                                                   8'($urandom), pick_weight(), 1'($urandom));
          else send_item(ACT_WEIGHT, 8'($urandom_range(0, nl - 1)),
                         8'($urandom_range(nh, 255)), pick_weight(), 1'($urandom));
          sent++;
        end
        9: begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(ACT_FINALIZE, 8'($urandom), 8'($urandom), WEIGHT_W'($urandom), 1'($urandom));
          end else begin
            send_item(ACT_WEIGHT, 8'($urandom_range(0, nl - 1)), 8'($urandom_range(0, nh - 1)),
                      pick_weight(), 1'b0);
          end
          sent++;
        end
        default: begin
          lay = 8'($urandom_range(0, nl - 1));
          hd = 8'($urandom_range(0, nh - 1));
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            send_item(ACT_WEIGHT, lay, hd, pick_weight(), i == len - 1);
          sent += len;
        end
      endcase
    end
  endtask

  // Waits until every expected result has come, then lets a weight still in flight finish
  // before the registers may be touched again.
  task drain();
    item_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Zero counts read as one layer and one head; a zero threshold never sets focus.
    // Values wider than six bits check that only the low bits of the count are kept.
    set_config(24'hFFFFC0, 24'h000040, 24'd0);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'd0, 1'b1);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'd30000, 1'b1);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, ONE_Q16, 1'b0);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'd1, 1'b0);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'd65535, 1'b0);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'd32768, 1'b0);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'h1FFFF, 1'b0);
    send_item(ACT_WEIGHT, 8'd0, 8'd0, 17'd0, 1'b1);
    send_item(ACT_WEIGHT, 8'd1, 8'd0, 17'd20000, 1'b1);
    send_item(ACT_WEIGHT, 8'd0, 8'd255, 17'd20000, 1'b1);
    send_item(ACT_WEIGHT, 8'd255, 8'd255, 17'd20000, 1'b1);
    send_item(ACT_FINALIZE, 8'hFF, 8'hFF, 17'h1FFFF, 1'b1);
    drain();

    // Counts above the maximum clamp to it; a threshold at full scale focuses almost always.
    set_config(24'd63, 24'd63, ENT_MAX);
    // Two heads interleaved: the closing transaction takes the whole sum.
    send_item(ACT_WEIGHT, 8'd3, 8'd5, 17'd12000, 1'b0);
    send_item(ACT_WEIGHT, 8'd4, 8'd6, 17'd40000, 1'b0);
    send_item(ACT_WEIGHT, 8'd4, 8'd6, 17'd40000, 1'b1);
    send_item(ACT_WEIGHT, 8'd31, 8'd0, 17'd5, 1'b1);
    send_item(ACT_WEIGHT, 8'd32, 8'd0, 17'd5, 1'b1);
    send_item(ACT_WEIGHT, 8'd0, 8'd32, 17'd5, 1'b1);
    // A longer vector on layer 31, head 31, sent back to back; the peak of one lands in
    // the middle of it, so its position is not the first.
    quiet = 1'b1;
    for (int i = 0; i < 10; i++)
      send_item(ACT_WEIGHT, 8'd31, 8'd31, (i == 5) ? ONE_Q16 : 17'd24109, i == 9);
    quiet = 1'b0;
    random_traffic(20);
    send_item(ACT_FINALIZE, 8'd0, 8'd0, 17'd0, 1'b0);
    drain();

    // A small geometry with a random threshold; the result side holds off for a long stretch
    // meanwhile, so that the output register fills and the input side stalls.
    set_config(24'd4, 24'd3, 24'($urandom_range(0, 200000)));
    hold_req = 1'b1;
    random_traffic(30);
    send_item(ACT_FINALIZE, 8'd0, 8'd0, 17'd0, 1'b0);
    drain();

    // Back to the defaults, with no idling on either side.
    set_config(24'd32, 24'd32, 24'd163840);
    quiet = 1'b1;
    random_traffic(30);
    send_item(ACT_FINALIZE, 8'd0, 8'd0, 17'd0, 1'b0);
    drain();

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a run that has not finished by this time fails.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/aet_pkg.sv
hw/rtl/aet_ram.sv
hw/rtl/aet_div.sv
hw/rtl/attention_entropy_telemetry.sv
hw/rtl/aet_checker.sv
test/tb_attention_entropy_telemetry.sv
